[src/i2d_pkg.sv]
package i2d_pkg;

   localparam int VALUE_W    = 64;
   localparam int NUM_DIGITS = 20;
   localparam int DIGIT_W    = 4;
   localparam int CHAR_W     = 8;
   localparam int BITCNT_W   = $clog2(VALUE_W);
   localparam int DIGCNT_W   = $clog2(NUM_DIGITS + 1);

   localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 8'd48;
   localparam logic [CHAR_W-1:0]  ASCII_MINUS = 8'd45;
   localparam logic [DIGIT_W-1:0] DABBLE_MIN  = 4'd5;
   localparam logic [DIGIT_W-1:0] DABBLE_ADD  = 4'd3;
   localparam logic [DIGIT_W-1:0] DIGIT_MAX   = 4'd9;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_CLEAR,
      OP_DABBLE,
      OP_SHIFT
   } i2d_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SKIP,
      ST_SIGN,
      ST_EMIT
   } i2d_state_type;

endpackage

[src/i2d_cell.sv]
module i2d_cell (
   input  logic                           clock,
   input  i2d_pkg::i2d_op_type            op,
   input  logic                           bit_in,
   input  logic [i2d_pkg::DIGIT_W-1:0]    digit_in,
   output logic                           bit_out,
   output logic [i2d_pkg::DIGIT_W-1:0]    digit_out
);
   import i2d_pkg::*;

   logic [DIGIT_W-1:0] digit_ff;
   logic [DIGIT_W-1:0] digit_in_next;
   logic [DIGIT_W-1:0] adjusted;

   // Add three before the shift so that a digit of five or more carries out as ten.
   assign adjusted  = (digit_ff >= DABBLE_MIN) ? digit_ff + DABBLE_ADD : digit_ff;
   assign bit_out   = adjusted[DIGIT_W-1];
   assign digit_out = digit_ff;

   always_comb begin
      unique case (op)
         OP_HOLD:   digit_in_next = digit_ff;
         OP_CLEAR:  digit_in_next = '0;
         OP_DABBLE: digit_in_next = {adjusted[DIGIT_W-2:0], bit_in};
         OP_SHIFT:  digit_in_next = digit_in;
         default:   digit_in_next = digit_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in_next;
   end

endmodule

[src/int64_to_decimal_ascii.sv]
// Converts a 64-bit value, read as unsigned or as two's-complement signed according to
// req_func, into its decimal ASCII text, one character per response, most significant
// digit first, without leading zeros, with rsp_last on the final character. A negative
// value starts with '-'. One request is worked on at a time: after acceptance the
// magnitude is shifted one bit per cycle through a row of twenty BCD digit cells until
// all 64 bits are in, then the row shifts one digit per cycle past leading zeros, and
// then one character is loaded per cycle into the output register while it is free.
// The next request is accepted once the last character has been loaded.
module int64_to_decimal_ascii (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_func,
   input  logic [i2d_pkg::VALUE_W-1:0]  req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [i2d_pkg::CHAR_W-1:0]   rsp_ch,
   output logic                         rsp_last
);
   import i2d_pkg::*;

   i2d_state_type         state_ff, state_in;
   logic [VALUE_W-1:0]    mag_ff, mag_in;
   logic                  neg_ff, neg_in;
   logic [BITCNT_W-1:0]   bitcnt_ff, bitcnt_in;
   logic [DIGCNT_W-1:0]   digcnt_ff, digcnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]     rsp_ch_ff, rsp_ch_in;
   logic                  rsp_last_ff, rsp_last_in;

   i2d_op_type            cell_op;
   logic                  carry   [NUM_DIGITS];
   logic [DIGIT_W-1:0]    digit   [NUM_DIGITS];
   logic [DIGIT_W-1:0]    top_digit;
   logic                  req_accept;
   logic                  out_free;
   logic                  req_neg;

   assign top_digit  = digit[NUM_DIGITS-1];
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_neg    = req_func && req_value[VALUE_W-1];

   // Cell zero holds the least significant digit and takes the magnitude's top bit.
   for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
      logic               bit_in;
      logic [DIGIT_W-1:0] digit_below;
      if (i == 0) begin : g_first
         assign bit_in      = mag_ff[VALUE_W-1];
         assign digit_below = '0;
      end else begin : g_next
         assign bit_in      = carry[i-1];
         assign digit_below = digit[i-1];
      end
      i2d_cell u_cell (
         .clock     (clock),
         .op        (cell_op),
         .bit_in    (bit_in),
         .digit_in  (digit_below),
         .bit_out   (carry[i]),
         .digit_out (digit[i])
      );
   end

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      bitcnt_in    = bitcnt_ff;
      digcnt_in    = digcnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_ch_in    = rsp_ch_ff;
      rsp_last_in  = rsp_last_ff;
      cell_op      = OP_HOLD;
      req_stall    = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               mag_in    = req_neg ? (~req_value) + 1'b1 : req_value;
               neg_in    = req_neg;
               bitcnt_in = '0;
               cell_op   = OP_CLEAR;
               state_in  = ST_CONV;
            end
         end
         ST_CONV: begin
            cell_op   = OP_DABBLE;
            mag_in    = {mag_ff[VALUE_W-2:0], 1'b0};
            bitcnt_in = bitcnt_ff + 1'b1;
            if (bitcnt_ff == BITCNT_W'(VALUE_W - 1)) begin
               digcnt_in = DIGCNT_W'(NUM_DIGITS);
               state_in  = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (top_digit == '0 && digcnt_ff > DIGCNT_W'(1)) begin
               cell_op   = OP_SHIFT;
               digcnt_in = digcnt_ff - 1'b1;
            end else begin
               state_in = neg_ff ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ch_in    = ASCII_MINUS;
               rsp_last_in  = 1'b0;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ch_in    = ASCII_ZERO + CHAR_W'(top_digit);
               rsp_last_in  = (digcnt_ff == DIGCNT_W'(1));
               cell_op      = OP_SHIFT;
               digcnt_in    = digcnt_ff - 1'b1;
               if (digcnt_ff == DIGCNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      bitcnt_ff   <= bitcnt_in;
      digcnt_ff   <= digcnt_in;
      rsp_ch_ff   <= rsp_ch_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_ch    = rsp_ch_ff;
   assign rsp_last  = rsp_last_ff;

   a_accept_starts_conv: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == ST_CONV)
      else $error("accepted request did not start a conversion");

   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ch_ff == ASCII_MINUS ||
                        (rsp_ch_ff >= ASCII_ZERO && rsp_ch_ff <= ASCII_ZERO + 8'd9)))
      else $error("response character is neither a digit nor a minus sign");

   a_emit_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT || state_ff == ST_SIGN) |-> digcnt_ff != '0)
      else $error("emitting with no digits left");

   a_top_bcd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SKIP || state_ff == ST_EMIT) |-> top_digit <= DIGIT_MAX)
      else $error("top digit cell holds a non-decimal value");

   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SIGN && out_free) |=> rsp_valid_ff && !rsp_last_ff)
      else $error("minus sign was flagged as the last character");

endmodule
